// ===== rtl/core/rbd_pkg.sv =====
package rbd_pkg;

  // Channel widths of RGB555 and of one per-channel sum of four values
  localparam int unsigned CH_W  = 5;
  localparam int unsigned SUM_W = 7;

  // Bit that marks every scaled pixel
  localparam logic [15:0] OPAQUE_BIT = 16'h8000;

  typedef struct packed {
    logic [15:0] pixel;
    logic        frame_start;
  } pix_beat_t;

  typedef struct packed {
    logic [15:0] scaled_pixel;
    logic [5:0]  out_col;
    logic [5:0]  out_row;
    logic        frame_end;
  } res_beat_t;

  // Three per-channel sums, blue on top as in the pixel word
  typedef struct packed {
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] r;
  } sums_t;

  // Widen the three channels of a pixel into sum fields
  function automatic sums_t spread(input logic [15:0] px);
    sums_t s;
    s.r = SUM_W'(px[4:0]);
    s.g = SUM_W'(px[9:5]);
    s.b = SUM_W'(px[14:10]);
    return s;
  endfunction

  // Divide each sum by four, truncating, and pack as RGB555
  function automatic logic [14:0] quarter(input sums_t s);
    return {s.b[SUM_W-1:2], s.g[SUM_W-1:2], s.r[SUM_W-1:2]};
  endfunction

  function automatic sums_t add_sums(input sums_t a, input sums_t c);
    sums_t s;
    s.r = a.r + c.r;
    s.g = a.g + c.g;
    s.b = a.b + c.b;
    return s;
  endfunction

endpackage

// ===== rtl/core/rbd_line_store.sv =====
module rbd_line_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rbd_pkg::sums_t rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rbd_pkg::sums_t wr_data
);
  import rbd_pkg::*;

  sums_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/rgb555_box_downscale_4x4.sv =====
// 4x4 box-filter downscaler for RGB555 video.
//
// pix channel: one source pixel per beat in raster order, frame_start set on
// the first pixel of a frame (it restarts the position counters). Pixels at
// columns 4*OUT_WIDTH and up and trailing partial groups or bands are dropped.
// res channel: one scaled pixel per 4x4 block, bit 15 set, with its output
// column and row; frame_end marks the last block of the frame.
//
// Throughput is one pixel per clock while pix is not stalled. The line
// store has one read and one write port; a group of four pixels reads its
// column entry once and writes it back from the write-back stage, and the
// same entry is not read again for at least four beats, so no forwarding
// is needed. The result of a block passes the write-back stage and then
// the output register after the beat that carries the block's last pixel.
// Reset clears the position counters and empties the pipeline; the line
// store needs no clearing pass, since the first row of a band overwrites it.
// When res is stalled with a result held, one more block completion can wait
// in the write-back stage; pix is stalled for as long as it waits there.
module rgb555_box_downscale_4x4 #(
  parameter int SRC_WIDTH  = 256,
  parameter int SRC_HEIGHT = 192,
  parameter int OUT_WIDTH  = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  output logic               pix_stall,
  input  rbd_pkg::pix_beat_t pix,
  output logic               res_valid,
  input  logic               res_stall,
  output rbd_pkg::res_beat_t res
);
  import rbd_pkg::*;

  localparam int CW = $clog2(SRC_WIDTH);
  localparam int RW = $clog2(SRC_HEIGHT);
  localparam int AW = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
  localparam logic [31:0] LAST_OCOL = 32'(OUT_WIDTH - 1);
  localparam logic [31:0] LAST_OROW = 32'(SRC_HEIGHT / 4 - 1);

  // Position and horizontal group state
  logic [CW-1:0] src_col, src_col_next;
  logic [RW-1:0] src_row, src_row_next;
  sums_t         horiz_sums, horiz_sums_next;

  // Write-back stage
  logic          s1_valid;
  sums_t         s1_avg;
  logic [AW-1:0] s1_addr;
  logic          s1_first;
  logic          s1_last;
  logic [5:0]    s1_col;
  logic [5:0]    s1_row;
  logic          s1_fend;
  logic          s1_go;

  logic          accept;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [31:0]   ocol;
  logic [31:0]   orow;
  logic          in_range;
  logic          group_done;
  sums_t         rd_data;
  sums_t         vert_sum;

  // Stall only when a finished block cannot move into the output register
  assign s1_go     = s1_valid && (!s1_last || !res_valid || !res_stall);
  assign pix_stall = s1_valid && !s1_go;
  assign accept    = pix_valid && !pix_stall;

  // Position of this pixel, restarted by frame_start
  always_comb begin
    col_eff    = pix.frame_start ? '0 : src_col;
    row_eff    = pix.frame_start ? '0 : src_row;
    ocol       = 32'(col_eff) >> 2;
    orow       = 32'(row_eff) >> 2;
    in_range   = ocol < 32'(OUT_WIDTH);
    group_done = in_range && (col_eff[1:0] == 2'd3);
  end

  // Advance the counters with wrap at the frame edges
  always_comb begin
    col_inc      = {1'b0, col_eff} + 1'b1;
    row_inc      = {1'b0, row_eff} + 1'b1;
    src_col_next = col_inc[CW-1:0];
    src_row_next = row_eff;
    if (col_inc >= (CW+1)'(SRC_WIDTH)) begin
      src_col_next = '0;
      src_row_next = row_inc[RW-1:0];
      if (row_inc >= (RW+1)'(SRC_HEIGHT)) begin
        src_row_next = '0;
      end
    end
  end

  // Accumulate the horizontal group
  always_comb begin
    horiz_sums_next = horiz_sums;
    if (in_range) begin
      if (col_eff[1:0] == 2'd0) begin
        horiz_sums_next = spread(pix.pixel);
      end else begin
        horiz_sums_next = add_sums(horiz_sums, spread(pix.pixel));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col <= '0;
      src_row <= '0;
    end else if (accept) begin
      src_col <= src_col_next;
      src_row <= src_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      horiz_sums <= horiz_sums_next;
    end
  end

  // Hand a finished group to the write-back stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= group_done;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && group_done) begin
      s1_avg   <= spread({1'b0, quarter(horiz_sums_next)});
      s1_addr  <= ocol[AW-1:0];
      s1_first <= (row_eff[1:0] == 2'd0);
      s1_last  <= (row_eff[1:0] == 2'd3);
      s1_col   <= ocol[5:0];
      s1_row   <= orow[5:0];
      s1_fend  <= (ocol == LAST_OCOL) && (orow == LAST_OROW);
    end
  end

  // Read the column entry with the group, write it back one stage later
  rbd_line_store #(
    .DEPTH (OUT_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept && group_done),
    .rd_addr (ocol[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_addr),
    .wr_data (vert_sum)
  );

  assign vert_sum = s1_first ? s1_avg : add_sums(rd_data, s1_avg);

  // Output register: load on a completed band, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      res.scaled_pixel <= OPAQUE_BIT | {1'b0, quarter(vert_sum)};
      res.out_col      <= s1_col;
      res.out_row      <= s1_row;
      res.frame_end    <= s1_fend;
    end
  end

endmodule

// ===== rtl/core/rbd_checker.sv =====
module rbd_checker #(
  parameter int SRC_HEIGHT = 192,
  parameter int OUT_WIDTH  = 64
) (
  input logic               clk,
  input logic               rst,
  input logic               pix_stall,
  input rbd_pkg::res_beat_t res,
  input logic               res_valid,
  input logic               res_stall
);
  import rbd_pkg::*;

  localparam logic [31:0] LAST_OCOL = 32'(OUT_WIDTH - 1);
  localparam logic [31:0] LAST_OROW = 32'(SRC_HEIGHT / 4 - 1);

  // A stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // Every scaled pixel carries the marker bit
  a_marker: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.scaled_pixel[15])
    else $error("scaled pixel without bit 15");

  // frame_end only on the last block position
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_end |->
      res.out_col == LAST_OCOL[5:0] && res.out_row == LAST_OROW[5:0])
    else $error("frame_end away from the last block");

  // With the output register empty the input is never held off
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !pix_stall)
    else $error("pixel input stalled with no result pending");

endmodule

bind rgb555_box_downscale_4x4 rbd_checker #(
  .SRC_HEIGHT (SRC_HEIGHT),
  .OUT_WIDTH  (OUT_WIDTH)
) u_rbd_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_stall (pix_stall),
  .res       (res),
  .res_valid (res_valid),
  .res_stall (res_stall)
);

// ===== tb/sv/tb_rgb555_box_downscale_4x4.sv =====
module tb_rgb555_box_downscale_4x4;
  import rbd_pkg::*;

  localparam int SRC_W = 256;
  localparam int SRC_H = 192;
  localparam int OUT_W = 64;
  localparam int OUT_H = SRC_H / 4;

  // Source columns sent in the output row of each stretch
  localparam int EXTREME_COLS       = 64;
  localparam int PHASE_COLS         = 32;
  localparam int HOLD_COLS          = 64;
  localparam int HOLD_CYCLES        = 400;
  localparam int DRAIN_CYCLES       = 16;
  // Longest quiet stretch is the hold-off plus a run of random stalls and idles
  localparam int STUCK_LIMIT        = 5000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      pix_valid = 1'b0;
  logic      pix_stall;
  pix_beat_t pix       = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_beat_t res;

  int unsigned send_idle_pct     = 0;
  int unsigned stall_pct         = 0;
  int unsigned hold_request      = 0;
  int unsigned hold_left         = 0;
  int unsigned stuck_cycles      = 0;
  int unsigned pixels_sent       = 0;
  int unsigned results_predicted = 0;
  int unsigned results_checked   = 0;
  int unsigned mismatches        = 0;

  // Predictor state: source position, current group sums, one band of column sums
  int unsigned col_pos    = 0;
  int unsigned row_pos    = 0;
  sums_t       group_sums = '0;
  sums_t       band_sums [OUT_W];
  res_beat_t   pending_scaled [$];

  rgb555_box_downscale_4x4 #(
    .SRC_WIDTH (SRC_W),
    .SRC_HEIGHT(SRC_H),
    .OUT_WIDTH (OUT_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix      (pix),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always #5 clk = ~clk;

  // Widen each 5-bit channel of a pixel to a 7-bit sum
  function automatic sums_t channel_sums(logic [15:0] px);
    sums_t s;
    s.r = {2'b00, px[4:0]};
    s.g = {2'b00, px[9:5]};
    s.b = {2'b00, px[14:10]};
    return s;
  endfunction

  // Divide every sum by four, truncating
  function automatic sums_t quarter_sums(sums_t s);
    sums_t q;
    q.r = s.r >> 2;
    q.g = s.g >> 2;
    q.b = s.b >> 2;
    return q;
  endfunction

  function automatic sums_t plus_sums(sums_t a, sums_t c);
    sums_t s;
    s.r = a.r + c.r;
    s.g = a.g + c.g;
    s.b = a.b + c.b;
    return s;
  endfunction

  // Work out the scaled pixel, if any, that one accepted source beat completes
  function automatic void predict_scaled(pix_beat_t beat);
    int unsigned ocol;
    int unsigned orow;
    sums_t       avg;
    sums_t       tot;
    res_beat_t   want;
    if (beat.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    ocol = col_pos / 4;
    orow = row_pos / 4;
    if (ocol < OUT_W) begin
      if (col_pos % 4 == 0) group_sums = channel_sums(beat.pixel);
      else group_sums = plus_sums(group_sums, channel_sums(beat.pixel));
      if (col_pos % 4 == 3) begin
        avg = quarter_sums(group_sums);
        tot = (row_pos % 4 == 0) ? avg : plus_sums(band_sums[ocol], avg);
        band_sums[ocol] = tot;
        if (row_pos % 4 == 3) begin
          tot = quarter_sums(tot);
          want.scaled_pixel = {1'b1, tot.b[4:0], tot.g[4:0], tot.r[4:0]};
          want.out_col      = ocol[5:0];
          want.out_row      = orow[5:0];
          want.frame_end    = (ocol == OUT_W - 1) && (orow == OUT_H - 1);
          pending_scaled.push_back(want);
          results_predicted++;
        end
      end
    end
    // Advance the raster position, wrapping at the frame edges
    col_pos++;
    if (col_pos >= SRC_W) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= SRC_H) row_pos = 0;
    end
  endfunction

  // Compare one result beat with the oldest scaled pixel still owed
  function automatic void check_scaled(res_beat_t got);
    res_beat_t want;
    results_checked++;
    if (pending_scaled.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: pixel %h col %0d row %0d end %b",
                 got.scaled_pixel, got.out_col, got.out_row, got.frame_end);
      return;
    end
    want = pending_scaled.pop_front();
    if (got.scaled_pixel !== want.scaled_pixel || got.out_col !== want.out_col ||
        got.out_row !== want.out_row || got.frame_end !== want.frame_end) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected pixel %h col %0d row %0d end %b,",
                  " got %h col %0d row %0d end %b"},
                 want.scaled_pixel, want.out_col, want.out_row, want.frame_end,
                 got.scaled_pixel, got.out_col, got.out_row, got.frame_end);
    end
  endfunction

  // Observe both channels at each edge: predict on source beats, check result beats
  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall) predict_scaled(pix);
    if (!rst && res_valid && !res_stall) check_scaled(res);
  end

  // Drive the result stall: a requested hold-off first, random stalls otherwise
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // End the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", stuck_cycles);
      $display("tb_rgb555_box_downscale_4x4 failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offer one source beat after a random idle gap and hold it until accepted
  task automatic send_pixel(logic [15:0] px, logic fs);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= '{pixel: px, frame_start: fs};
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Random pixel, biased towards saturated and empty channels; bit 15 toggles freely
  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(7))
      0:       return {1'($urandom_range(1)), 15'h7FFF};
      1:       return {1'($urandom_range(1)), 15'h0000};
      default: return 16'($urandom);
    endcase
  endfunction

  // Fixed patterns over a band: full and empty channels, ignored top bit, truncation
  task automatic test_extremes();
    int unsigned c;
    int unsigned r;
    logic [15:0] px;
    for (r = 0; r < 4; r++) begin
      for (c = 0; c < ((r == 3) ? EXTREME_COLS : SRC_W); c++) begin
        case ((c / 4) % 8)
          0: px = 16'h7FFF;
          1: px = 16'h0000;
          2: px = 16'hFFFF;
          3: px = 16'h8000;
          4: px = 16'h001F;
          5: px = 16'h03E0;
          6: px = 16'h7C00;
          // ones in three rows only: vertical sum of three must truncate to zero
          default: px = (r == 3) ? 16'h0000 : ((c % 4 == 0) ? 16'h0C63 : 16'h0421);
        endcase
        send_pixel(px, (r == 0) && (c == 0));
      end
    end
  endtask

  // Frame starts part-way through a band and inside a group, then three rows
  task automatic test_restart();
    int unsigned n;
    send_pixel(rand_pixel(), 1'b1);
    send_pixel(rand_pixel(), 1'b0);
    send_pixel(rand_pixel(), 1'b1);
    for (n = 1; n < 3 * SRC_W; n++) send_pixel(rand_pixel(), 1'b0);
  endtask

  // Output row of the band under the sender and receiver idling phases
  task automatic test_random();
    int unsigned phase;
    int unsigned n;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 58; stall_pct = 0;  end
        1:       begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      for (n = 0; n < PHASE_COLS; n++) send_pixel(rand_pixel(), 1'b0);
    end
  endtask

  // Hold off results through more of the output row so the source side stalls
  task automatic test_backpressure();
    int unsigned n;
    hold_request = HOLD_CYCLES;
    for (n = 0; n < HOLD_COLS; n++) send_pixel(rand_pixel(), 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    send_idle_pct = 58;
    test_restart();
    test_random();
    send_idle_pct = 0;
    stall_pct     = 0;
    test_backpressure();
    pix_valid <= 1'b0;

    // Drain outstanding results, then allow for the pipeline depth
    while (pending_scaled.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d source beats and %0d scaled pixels, %0d mismatches",
             pixels_sent, results_checked, mismatches);
    $display("patterns, restarts mid-band and mid-group, idling phases and a long hold-off");
    if (mismatches == 0 && pending_scaled.size() == 0) begin
      $display("tb_rgb555_box_downscale_4x4 passed");
    end else begin
      $display("tb_rgb555_box_downscale_4x4 failed");
    end
    $finish;
  end

endmodule
